// File: design/anf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anf_pkg: shared types, constants and helpers of the advertising name filter
// Holds the channel words, the register set and the character helpers.
// ----------------------------------------------------------------------------
package anf_pkg;

    localparam int NAME_CAPACITY = 9;
    localparam int NAME_LEN_W    = 4;

    // Parser phases.
    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // AD types that carry a local name.
    localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
    localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;

    // Word kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    // Register indexes.
    localparam logic [1:0] REG_TARGET_LENGTH = 2'd0;
    localparam logic [1:0] REG_TARGET_HEAD   = 2'd1;
    localparam logic [1:0] REG_TARGET_TAIL   = 2'd2;
    localparam logic [1:0] REG_OWN_IDENTITY  = 2'd3;

    // Own name prefix characters.
    localparam logic [7:0] CH_J  = 8'h4A;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_US = 8'h5F;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] packet_len;
    } in_word_t;

    typedef struct packed {
        logic verdict_kind;
        logic peer_match;
    } out_word_t;

    typedef logic [NAME_CAPACITY-1:0][7:0] name_bytes_t;

    typedef struct packed {
        logic [NAME_LEN_W-1:0] length;
        name_bytes_t           bytes;
    } name_t;

    typedef struct packed {
        logic [3:0]  target_length;
        logic [63:0] target_head;
        logic [7:0]  target_tail;
        logic [23:0] own_identity;
    } cfg_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

endpackage

// File: design/adv_name_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adv_name_filter: local-name filter for advertising payloads
// Walks the fields of each packet, keeps the last short enough local name and
// reports a per-packet verdict and a per-window summary.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word type          Handshake
//  s_*       in         anf_pkg::in_word_t  s_valid / s_ready
//  m_*       out        anf_pkg::out_word_t m_valid / m_ready
//  APB       in/out     64-bit registers    psel / penable, pready tied high
//
// One word per cycle is sustained while the result is drained (m_ready high):
// the input register feeds the parser and the name compare, which settle
// combinationally into the result register, the second register on the path.
// A stalled result holds in the result register while one more word waits in
// the input register; s_ready drops only when both are full.
// Reset (aresetn low at a clock edge) empties both registers, restarts the
// parser and clears the registers and the window flag.
// ----------------------------------------------------------------------------
module adv_name_filter (
    input  logic               aclk,
    input  logic               aresetn,
    // Input words.
    input  logic               s_valid,
    output logic               s_ready,
    input  anf_pkg::in_word_t  s_data,
    // Result words.
    output logic               m_valid,
    input  logic               m_ready,
    output anf_pkg::out_word_t m_data,
    // Register port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    anf_pkg::cfg_t      cfg_reg;
    anf_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    anf_pkg::out_word_t out_word_reg;
    logic               out_valid_reg;
    logic               window_seen_reg, window_seen_next;
    logic               fire;
    logic               pkt_done;
    logic               match;
    logic               result_valid;
    anf_pkg::out_word_t result;
    anf_pkg::name_t     name_next;
    logic [1:0]         reg_index;

    // ------------------------------------------------------------------
    // Register port. Registers sit at eight-byte strides, so the index is
    // taken from the upper address bits.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_index)
                anf_pkg::REG_TARGET_LENGTH: cfg_reg.target_length <= pwdata[3:0];
                anf_pkg::REG_TARGET_HEAD:   cfg_reg.target_head   <= pwdata;
                anf_pkg::REG_TARGET_TAIL:   cfg_reg.target_tail   <= pwdata[7:0];
                anf_pkg::REG_OWN_IDENTITY:  cfg_reg.own_identity  <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            anf_pkg::REG_TARGET_LENGTH: prdata = {60'd0, cfg_reg.target_length};
            anf_pkg::REG_TARGET_HEAD:   prdata = cfg_reg.target_head;
            anf_pkg::REG_TARGET_TAIL:   prdata = {56'd0, cfg_reg.target_tail};
            anf_pkg::REG_OWN_IDENTITY:  prdata = {40'd0, cfg_reg.own_identity};
            default:                    prdata = 64'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register. The held word is processed as soon as the result
    // register is empty or being drained in the same cycle.
    // ------------------------------------------------------------------
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Field walk and name compare. The compare sees the name as it stands
    // after the current byte, so the last byte of a packet counts.
    // ------------------------------------------------------------------
    anf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .item      (in_word_reg),
        .name_next (name_next),
        .pkt_done  (pkt_done)
    );

    anf_match u_match (
        .name  (name_next),
        .cfg   (cfg_reg),
        .match (match)
    );

    // A window word reports the sticky flag and clears it; a packet that
    // matches sets it.
    always_comb begin
        window_seen_next = window_seen_reg;
        result_valid     = 1'b0;
        result           = '0;
        if (fire) begin
            if (in_word_reg.kind == anf_pkg::KIND_WINDOW) begin
                result_valid        = 1'b1;
                result.verdict_kind = anf_pkg::KIND_WINDOW;
                result.peer_match   = window_seen_reg;
                window_seen_next    = 1'b0;
            end else if (pkt_done) begin
                result_valid        = 1'b1;
                result.verdict_kind = anf_pkg::KIND_BYTE;
                result.peer_match   = match;
                window_seen_next    = window_seen_reg | match;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_seen_reg <= 1'b0;
        end else begin
            window_seen_reg <= window_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= result_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result_valid) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_result_from_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(fire))
        else $error("result appeared without a processed word");

    a_window_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_word_reg.kind == anf_pkg::KIND_WINDOW) |=> !window_seen_reg)
        else $error("window flag not cleared by a window word");

    a_match_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_word_reg.kind == anf_pkg::KIND_BYTE && pkt_done && match)
        |=> window_seen_reg)
        else $error("matching packet did not set the window flag");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while a stage was free");

endmodule

// File: design/anf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anf_parser: length-type-value walker and name capture
// Steps the parser state by one payload byte and reports the end of a packet.
// ----------------------------------------------------------------------------
module anf_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  anf_pkg::in_word_t item,
    output anf_pkg::name_t   name_next,
    output logic             pkt_done
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] field_left_reg, field_left_next;
    logic       capturing_reg, capturing_next;
    logic [anf_pkg::NAME_LEN_W-1:0] name_len_reg, name_len_next;
    anf_pkg::name_bytes_t name_reg, name_bytes_next;
    logic [7:0] remain;
    logic [7:0] fl_dec;

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        field_left_next = field_left_reg;
        capturing_next  = capturing_reg;
        name_len_next   = name_len_reg;
        name_bytes_next = name_reg;
        pkt_done        = 1'b0;
        remain          = bytes_left_reg;
        fl_dec          = 8'd0;
        if (step && item.kind == anf_pkg::KIND_BYTE) begin
            if (item.first_byte) begin
                remain          = item.packet_len;
                phase_next      = anf_pkg::PH_LEN;
                field_left_next = 8'd0;
                capturing_next  = 1'b0;
                name_len_next   = '0;
            end
            fl_dec = field_left_next - 8'd1;
            if (remain != 8'd0) begin
                unique case (phase_next)
                    anf_pkg::PH_LEN: begin
                        if (remain <= 8'd1 || item.data_byte == 8'd0 ||
                            item.data_byte > remain - 8'd1) begin
                            phase_next = anf_pkg::PH_STOP;
                        end else begin
                            field_left_next = item.data_byte;
                            phase_next      = anf_pkg::PH_TYPE;
                        end
                    end
                    anf_pkg::PH_TYPE: begin
                        field_left_next = fl_dec;
                        capturing_next  = (item.data_byte == anf_pkg::AD_SHORT_NAME ||
                                           item.data_byte == anf_pkg::AD_COMPLETE_NAME) &&
                                          fl_dec <= 8'(anf_pkg::NAME_CAPACITY);
                        if (capturing_next) begin
                            name_len_next = '0;
                        end
                        if (fl_dec == 8'd0) begin
                            capturing_next = 1'b0;
                            phase_next     = anf_pkg::PH_LEN;
                        end else begin
                            phase_next = anf_pkg::PH_VALUE;
                        end
                    end
                    anf_pkg::PH_VALUE: begin
                        if (capturing_next) begin
                            if (item.data_byte == 8'd0) begin
                                capturing_next = 1'b0;
                            end else if (name_len_next <
                                         anf_pkg::NAME_LEN_W'(anf_pkg::NAME_CAPACITY)) begin
                                name_bytes_next[name_len_next] = item.data_byte;
                                name_len_next = name_len_next + 1'b1;
                            end
                        end
                        field_left_next = fl_dec;
                        if (fl_dec == 8'd0) begin
                            capturing_next = 1'b0;
                            phase_next     = anf_pkg::PH_LEN;
                        end
                    end
                    default: begin
                    end
                endcase
                pkt_done = (remain == 8'd1);
                remain   = remain - 8'd1;
            end
            bytes_left_next = remain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= anf_pkg::PH_LEN;
            bytes_left_reg <= 8'd0;
            field_left_reg <= 8'd0;
            capturing_reg  <= 1'b0;
            name_len_reg   <= '0;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            field_left_reg <= field_left_next;
            capturing_reg  <= capturing_next;
            name_len_reg   <= name_len_next;
        end
    end

    // Bytes past the name length are never compared, so they need no reset.
    always_ff @(posedge aclk) begin
        name_reg <= name_bytes_next;
    end

    assign name_next.length = name_len_next;
    assign name_next.bytes  = name_bytes_next;

endmodule

// File: design/anf_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anf_match: name verdict
// Compares a captured name with the exact target or the peer name pattern.
// ----------------------------------------------------------------------------
module anf_match (
    input  anf_pkg::name_t name,
    input  anf_pkg::cfg_t  cfg,
    output logic           match
);

    logic [anf_pkg::NAME_CAPACITY-1:0] exact_ok;
    logic [anf_pkg::NAME_CAPACITY-1:0] own_eq;
    logic [anf_pkg::NAME_CAPACITY-1:0] hex_ok;
    anf_pkg::name_bytes_t target;
    anf_pkg::name_bytes_t own;
    logic exact_hit;
    logic pattern_hit;

    assign target = {cfg.target_tail, cfg.target_head};

    assign own[0] = anf_pkg::CH_J;
    assign own[1] = anf_pkg::CH_X;
    assign own[2] = anf_pkg::CH_US;
    assign own[3] = anf_pkg::hex_upper(cfg.own_identity[23:20]);
    assign own[4] = anf_pkg::hex_upper(cfg.own_identity[19:16]);
    assign own[5] = anf_pkg::hex_upper(cfg.own_identity[15:12]);
    assign own[6] = anf_pkg::hex_upper(cfg.own_identity[11:8]);
    assign own[7] = anf_pkg::hex_upper(cfg.own_identity[7:4]);
    assign own[8] = anf_pkg::hex_upper(cfg.own_identity[3:0]);

    always_comb begin
        for (int i = 0; i < anf_pkg::NAME_CAPACITY; i++) begin
            exact_ok[i] = (anf_pkg::NAME_LEN_W'(i) >= name.length) ||
                          (name.bytes[i] == target[i]);
            own_eq[i]   = (name.bytes[i] == own[i]);
            hex_ok[i]   = (i < 3) ? (name.bytes[i] == own[i])
                                  : anf_pkg::is_hex(name.bytes[i]);
        end
    end

    assign exact_hit   = (cfg.target_length == name.length) && (&exact_ok);
    assign pattern_hit = (name.length == anf_pkg::NAME_LEN_W'(anf_pkg::NAME_CAPACITY)) &&
                         (&hex_ok) && !(&own_eq);
    assign match       = (cfg.target_length != 4'd0) ? exact_hit : pattern_hit;

endmodule
